/* hdl/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SIPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sipq assertion failed");

// next-cycle implication, disabled while reset is low
`define SIPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sipq assertion failed");

`endif

/* hdl/sipq_pkg.sv */
// shared constants, codes and state type for the sorted insert priority queue
// no dependencies; used by the interfaces, the top level and the checker
`timescale 1ns / 1ps

package sipq_pkg;

	// store geometry
	localparam int CAPACITY = 16;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int STAT_W   = 2;

	// action codes
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_REMOVED  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_REM_HEAD,
		ST_REM_TAKE,
		ST_REM_RD,
		ST_REM_WR,
		ST_DONE
	} state_t;

endpackage

/* hdl/sipq_in_if.sv */
// operation channel of the priority queue: valid/ready plus action and key
// depends on sipq_pkg
`timescale 1ns / 1ps

interface sipq_in_if;
	logic                      valid;
	logic                      ready;
	logic                      action;
	logic [sipq_pkg::KEY_W-1:0] key;

	modport source (output valid, output action, output key, input ready);
	modport sink   (input valid, input action, input key, output ready);
endinterface

/* hdl/sipq_out_if.sv */
// result channel of the priority queue: valid/ready plus status, key and occupancy
// depends on sipq_pkg
`timescale 1ns / 1ps

interface sipq_out_if;
	logic                        valid;
	logic                        ready;
	logic [sipq_pkg::STAT_W-1:0] status;
	logic [sipq_pkg::KEY_W-1:0]  removed_key;
	logic [sipq_pkg::CNT_W-1:0]  occupancy;

	modport source (output valid, output status, output removed_key, output occupancy,
		input ready);
	modport sink   (input valid, input status, input removed_key, input occupancy,
		output ready);
endinterface

/* hdl/sipq_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module sipq_ram #(
	parameter int  WIDTH = 32,
	parameter int  DEPTH = 16,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/sorted_insert_priority_queue.sv */
// top level of the sorted insert priority queue: sequencer, compare unit, result register
// depends on sipq_pkg, sipq_in_if, sipq_out_if and sipq_ram
`timescale 1ns / 1ps

//  channel   | dir | payload                              | handshake
//  ----------+-----+--------------------------------------+-------------------
//  in_ch     | in  | action, key                          | valid / ready
//  out_ch    | out | status, removed_key, occupancy       | valid / ready
//  cfg       | in  | cfg_wr_data (largest_first)          | cfg_wr_en, no wait
//
//  insert: INS_RD reads the entry ahead and INS_CMP moves it back while the new key
//  outranks it; the key is written where the walk stops or at the front; remove:
//  REM_HEAD reads the head, REM_TAKE keeps it, REM_RD and REM_WR move each later entry
//  forward; the single ram read port and the one key compare unit serialise these steps
//  in_ch.ready is high only while the sequencer is idle; a finished result waits in
//  the output register, and the next operation can be taken while it waits
//  arst_n clears the entry count, the sequencer and the result valid; direction resets to 1

module sorted_insert_priority_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	sipq_in_if.sink     in_ch,
	sipq_out_if.source  out_ch
);

	import sipq_pkg::*;

	state_t               state_q, state_d;
	logic                 largest_first_q;
	logic [CNT_W-1:0]     count_q;
	logic [ADDR_W-1:0]    pos_q;
	logic [CNT_W-1:0]     idx_q;
	logic [KEY_W-1:0]     key_q;
	logic [KEY_W-1:0]     removed_q;
	logic [STAT_W-1:0]    status_q;

	logic                 out_valid_q;
	logic [STAT_W-1:0]    out_status_q;
	logic [KEY_W-1:0]     out_removed_q;
	logic [CNT_W-1:0]     out_occ_q;

	logic                 in_fire;
	logic                 out_load;
	logic                 is_full;
	logic                 is_empty;
	logic                 outrank;
	logic                 walk_end;
	logic                 sweep_end;
	logic [CNT_W-1:0]     idx_prev;

	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [KEY_W-1:0]     ram_wdata;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [KEY_W-1:0]     ram_rdata;

	// handshake and status flags
	assign in_fire   = in_ch.valid && in_ch.ready;
	assign out_load  = !out_valid_q || out_ch.ready;
	assign is_full   = (count_q == CNT_W'(CAPACITY));
	assign is_empty  = (count_q == '0);
	assign walk_end  = (pos_q == '0);
	assign sweep_end = (idx_q == count_q);
	assign idx_prev  = idx_q - 1'b1;

	// shared compare unit: new key strictly ahead of the stored key
	assign outrank = largest_first_q ? (key_q > ram_rdata) : (key_q < ram_rdata);

	// entry store
	sipq_ram #(
		.WIDTH (KEY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in_ch.action == ACT_INSERT) begin
						state_d = is_full ? ST_DONE : ST_INS_RD;
					end else begin
						state_d = is_empty ? ST_DONE : ST_REM_HEAD;
					end
				end
			end
			ST_INS_RD:   state_d = walk_end ? ST_DONE : ST_INS_CMP;
			ST_INS_CMP:  state_d = outrank ? ST_INS_RD : ST_DONE;
			ST_REM_HEAD: state_d = ST_REM_TAKE;
			ST_REM_TAKE: state_d = ST_REM_RD;
			ST_REM_RD:   state_d = sweep_end ? ST_DONE : ST_REM_WR;
			ST_REM_WR:   state_d = ST_REM_RD;
			ST_DONE:     state_d = out_load ? ST_IDLE : ST_DONE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// ram port control per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = key_q;
		ram_raddr = '0;
		unique case (state_q)
			ST_INS_RD: begin
				if (walk_end) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr = pos_q - 1'b1;
				end
			end
			ST_INS_CMP: begin
				ram_we    = 1'b1;
				ram_wdata = outrank ? ram_rdata : key_q;
			end
			ST_REM_RD: begin
				ram_raddr = idx_q[ADDR_W-1:0];
			end
			ST_REM_WR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_prev[ADDR_W-1:0];
				ram_wdata = ram_rdata;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			largest_first_q <= 1'b1;
			count_q         <= '0;
			pos_q           <= '0;
			idx_q           <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				largest_first_q <= cfg_wr_data;
			end
			// walk and sweep counters
			if (in_fire) begin
				pos_q <= count_q[ADDR_W-1:0];
				idx_q <= CNT_W'(1);
			end else if (state_q == ST_INS_CMP && outrank) begin
				pos_q <= pos_q - 1'b1;
			end else if (state_q == ST_REM_WR) begin
				idx_q <= idx_q + 1'b1;
			end
			// entry count
			if ((state_q == ST_INS_RD && walk_end) || (state_q == ST_INS_CMP && !outrank)) begin
				count_q <= count_q + 1'b1;
			end else if (state_q == ST_REM_RD && sweep_end) begin
				count_q <= count_q - 1'b1;
			end
			// result valid
			if (state_q == ST_DONE && out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// operation payload and result fields
	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_q     <= in_ch.key;
			removed_q <= '0;
			if (in_ch.action == ACT_INSERT) begin
				status_q <= is_full ? STAT_FULL : STAT_INSERTED;
			end else begin
				status_q <= is_empty ? STAT_EMPTY : STAT_REMOVED;
			end
		end else if (state_q == ST_REM_TAKE) begin
			removed_q <= ram_rdata;
		end
		if (state_q == ST_DONE && out_load) begin
			out_status_q  <= status_q;
			out_removed_q <= removed_q;
			out_occ_q     <= count_q;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = out_status_q;
	assign out_ch.removed_key = out_removed_q;
	assign out_ch.occupancy   = out_occ_q;

endmodule

/* hdl/sipq_checker.sv */
// port-level checks for the sorted insert priority queue, bound to the top level
// depends on sipq_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sipq_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        out_valid,
	input  logic [sipq_pkg::STAT_W-1:0] out_status,
	input  logic [sipq_pkg::KEY_W-1:0]  out_removed_key,
	input  logic [sipq_pkg::CNT_W-1:0]  out_occupancy
);

	import sipq_pkg::*;

	logic res_not_rem;
	logic res_full;
	logic res_empty;

	// result qualifiers
	assign res_not_rem = out_valid && out_status != STAT_REMOVED;
	assign res_full    = out_valid && out_status == STAT_FULL;
	assign res_empty   = out_valid && out_status == STAT_EMPTY;

	// occupancy never passes the capacity
	`SIPQ_ASSERT_IMP(a_occ_max, clk, arst_n, out_valid, out_occupancy <= CNT_W'(CAPACITY))

	// only a real remove carries a key
	`SIPQ_ASSERT_IMP(a_key_zero, clk, arst_n, res_not_rem, out_removed_key == '0)

	// a rejected insert reports a full store
	`SIPQ_ASSERT_IMP(a_full_occ, clk, arst_n, res_full, out_occupancy == CNT_W'(CAPACITY))

	// a remove from nothing reports an empty store
	`SIPQ_ASSERT_IMP(a_empty_occ, clk, arst_n, res_empty, out_occupancy == '0)

	// the sequencer is busy right after a transfer is taken
	`SIPQ_ASSERT_NXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

bind sorted_insert_priority_queue sipq_checker u_sipq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_ch.valid),
	.in_ready        (in_ch.ready),
	.out_valid       (out_ch.valid),
	.out_status      (out_ch.status),
	.out_removed_key (out_ch.removed_key),
	.out_occupancy   (out_ch.occupancy)
);
